### sv/tcm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the terrace curve mapper
package tcm_pkg;

    // fixed field widths
    localparam int PT_W       = 16;
    localparam int DEN_W      = PT_W + 1;
    localparam int CNT_W      = 3;

    // alpha arithmetic
    localparam int ALPHA_FRAC  = 16;
    localparam int Q_BITS      = 26;
    localparam int ALPHA_CAP   = 1 << 24;
    localparam int ALPHA_ONE   = 1 << ALPHA_FRAC;
    localparam int ALPHA_LIMIT = 8 << ALPHA_FRAC;
    localparam int ALPHA_W     = 21;
    localparam int A2_W        = 39;
    localparam int A2R_W       = 23;
    localparam int PROD_W      = DEN_W + A2R_W + 1;
    localparam int TERM_W      = PROD_W + 1 - ALPHA_FRAC;
    localparam int ROUND_HALF  = 1 << (ALPHA_FRAC - 1);

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_COUNT      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INVERT     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POINT_BASE = 3'd2;

    // how a sample is resolved
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_END,
        KIND_SEG
    } kind_t;

    // per-transaction sideband carried alongside the divider
    typedef struct packed {
        kind_t                    kind;
        logic                     neg;
        logic                     num_zero;
        logic                     flag;
        logic signed [PT_W-1:0]   v0;
        logic signed [DEN_W-1:0]  diff;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

endpackage

### sv/tcm_front.sv
`timescale 1ns / 1ps
// segment search, end selection and divider operand preparation
module tcm_front #(
    parameter int MAX_POINTS  = 6,
    parameter int SAMPLE_BITS = 16,
    parameter int X_W         = 16,
    parameter int DIV_W       = 34
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic [SAMPLE_BITS-1:0]           sample_in,
    input  logic [tcm_pkg::CNT_W-1:0]        point_count,
    input  logic                             invert_terraces,
    input  logic [MAX_POINTS-1:0][2*tcm_pkg::PT_W-1:0] points,
    output logic                             out_valid,
    output tcm_pkg::side_t                   side,
    output logic [SAMPLE_BITS-1:0]           early,
    output logic [DIV_W-1:0]                 dividend,
    output logic [tcm_pkg::DEN_W-1:0]        divisor
);
    import tcm_pkg::*;

    localparam int NUM_W = X_W + 1;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam logic signed [X_W-1:0] S_MAX =
        {{(X_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [X_W-1:0] S_MIN = ~S_MAX;

    // stage a: point search
    logic [CNT_W-1:0]        n_pts;
    logic [CNT_W-1:0]        pos;
    logic [CNT_W-1:0]        i0_w;
    logic [CNT_W-1:0]        i1_w;
    logic signed [X_W-1:0]   x_ext;
    kind_t                   kind_a;

    logic                    a_valid_reg;
    logic signed [X_W-1:0]   a_x_reg;
    logic [IDX_W-1:0]        a_i0_reg;
    logic [IDX_W-1:0]        a_i1_reg;
    kind_t                   a_kind_reg;

    always_comb
    begin
        n_pts = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
        x_ext = X_W'($signed(sample_in));
        pos   = n_pts;
        for (int i = MAX_POINTS - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < n_pts) &&
                (x_ext < X_W'($signed(points[i][2*PT_W-1:PT_W]))))
            begin
                pos = CNT_W'(i);
            end
        end
        i0_w = (pos == '0) ? '0 : pos - 1'b1;
        i1_w = (pos == n_pts) ? n_pts - 1'b1 : pos;
        if (n_pts < CNT_W'(2))
        begin
            kind_a = KIND_PASS;
            i0_w   = '0;
            i1_w   = '0;
        end
        else if (i0_w == i1_w)
        begin
            kind_a = KIND_END;
        end
        else
        begin
            kind_a = KIND_SEG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg    <= x_ext;
            a_i0_reg   <= IDX_W'(i0_w);
            a_i1_reg   <= IDX_W'(i1_w);
            a_kind_reg <= kind_a;
        end
    end

    // stage b: segment ends, numerator and divisor
    logic signed [PT_W-1:0]   v0_b;
    logic signed [PT_W-1:0]   v1_b;
    logic signed [X_W-1:0]    v1_ext;
    logic signed [NUM_W-1:0]  num_b;
    logic signed [DEN_W-1:0]  den_b;
    logic [SAMPLE_BITS-1:0]   early_b;
    side_t                    side_b;

    logic                     b_valid_reg;
    logic signed [NUM_W-1:0]  b_num_reg;
    logic signed [DEN_W-1:0]  b_den_reg;
    logic [SAMPLE_BITS-1:0]   b_early_reg;
    side_t                    b_side_reg;

    always_comb
    begin
        v0_b   = $signed(points[a_i0_reg][PT_W-1:0]);
        v1_b   = $signed(points[a_i1_reg][PT_W-1:0]);
        v1_ext = X_W'(v1_b);
        num_b  = NUM_W'(a_x_reg) - NUM_W'(v0_b);
        den_b  = DEN_W'(v1_b) - DEN_W'(v0_b);

        side_b          = '0;
        side_b.kind     = a_kind_reg;
        side_b.v0       = invert_terraces ? v1_b : v0_b;
        side_b.diff     = invert_terraces ? -den_b : den_b;
        early_b         = '0;

        unique case (a_kind_reg)
            KIND_PASS:
            begin
                early_b = SAMPLE_BITS'(a_x_reg);
            end
            KIND_END:
            begin
                if (v1_ext > S_MAX)
                begin
                    early_b     = SAMPLE_BITS'(S_MAX);
                    side_b.flag = 1'b1;
                end
                else if (v1_ext < S_MIN)
                begin
                    early_b     = SAMPLE_BITS'(S_MIN);
                    side_b.flag = 1'b1;
                end
                else
                begin
                    early_b = SAMPLE_BITS'(v1_ext);
                end
            end
            KIND_SEG:
            begin
                early_b = '0;
            end
            default:
            begin
                early_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_num_reg   <= num_b;
            b_den_reg   <= den_b;
            b_early_reg <= early_b;
            b_side_reg  <= side_b;
        end
    end

    // stage c: magnitudes and signs for the divider
    logic [NUM_W-1:0]  num_abs;
    logic [DEN_W-1:0]  den_abs;
    logic              num_neg;
    logic              den_neg;
    side_t             side_c;

    logic              c_valid_reg;
    side_t             c_side_reg;
    logic [SAMPLE_BITS-1:0] c_early_reg;
    logic [DIV_W-1:0]  c_dividend_reg;
    logic [DEN_W-1:0]  c_divisor_reg;

    always_comb
    begin
        num_neg = b_num_reg[NUM_W-1];
        den_neg = b_den_reg[DEN_W-1];
        num_abs = num_neg ? NUM_W'(-b_num_reg) : NUM_W'(b_num_reg);
        den_abs = den_neg ? DEN_W'(-b_den_reg) : DEN_W'(b_den_reg);
        side_c          = b_side_reg;
        side_c.neg      = num_neg ^ den_neg;
        side_c.num_zero = (b_num_reg == '0);
        if ((b_side_reg.kind == KIND_SEG) && (b_den_reg == '0))
        begin
            side_c.flag = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg     <= side_c;
            c_early_reg    <= b_early_reg;
            c_dividend_reg <= {num_abs, {(ALPHA_FRAC+1){1'b0}}};
            c_divisor_reg  <= den_abs;
        end
    end

    assign out_valid = c_valid_reg;
    assign side      = c_side_reg;
    assign early     = c_early_reg;
    assign dividend  = c_dividend_reg;
    assign divisor   = c_divisor_reg;

endmodule

### sv/tcm_divider.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
module tcm_divider #(
    parameter int DIV_W  = 34,
    parameter int SIDE_W = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [DIV_W-1:0]            dividend,
    input  logic [tcm_pkg::DEN_W-1:0]   divisor,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [tcm_pkg::Q_BITS-1:0]  quot,
    output logic                        ovf,
    output logic [SIDE_W-1:0]           side_out
);
    import tcm_pkg::*;

    localparam int RW = (DIV_W > DEN_W + Q_BITS) ? DIV_W : DEN_W + Q_BITS;

    logic [Q_BITS:0]     valid_reg;
    logic [RW-1:0]       rem_reg  [0:Q_BITS-1];
    logic [DEN_W-1:0]    ud_reg   [0:Q_BITS-1];
    logic [Q_BITS-1:0]   q_reg    [0:Q_BITS];
    logic                ovf_reg  [0:Q_BITS];
    logic [SIDE_W-1:0]   side_reg [0:Q_BITS];

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[Q_BITS-1:0], in_valid};
        end
    end

    // entry stage: quotient range check
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= RW'(dividend);
            ud_reg[0]   <= divisor;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= RW'(dividend) >= (RW'(divisor) << Q_BITS);
            side_reg[0] <= side_in;
        end
    end

    // one trial subtraction per stage, msb first
    for (genvar s = 0; s < Q_BITS; s++)
    begin : g_bit
        localparam int K = Q_BITS - 1 - s;

        logic [RW-1:0]     sub_val;
        logic              take;
        logic [Q_BITS-1:0] q_next;

        always_comb
        begin
            sub_val   = RW'(ud_reg[s]) << K;
            take      = rem_reg[s] >= sub_val;
            q_next    = q_reg[s];
            q_next[K] = take;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[s+1]    <= q_next;
                ovf_reg[s+1]  <= ovf_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end

        if (s < Q_BITS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s+1] <= take ? rem_reg[s] - sub_val : rem_reg[s];
                    ud_reg[s+1]  <= ud_reg[s];
                end
            end
        end
    end

    assign out_valid = valid_reg[Q_BITS];
    assign quot      = q_reg[Q_BITS];
    assign ovf       = ovf_reg[Q_BITS];
    assign side_out  = side_reg[Q_BITS];

endmodule

### sv/tcm_back.sv
`timescale 1ns / 1ps
// alpha rounding and clipping, squaring, interpolation and output register
module tcm_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [tcm_pkg::Q_BITS-1:0]  quot,
    input  logic                        ovf,
    input  tcm_pkg::side_t              side,
    input  logic [SAMPLE_BITS-1:0]      early,
    input  logic                        invert_terraces,
    output logic                        out_valid,
    output logic [SAMPLE_BITS-1:0]      sample_out,
    output logic                        saturated
);
    import tcm_pkg::*;

    localparam int STAGES = 7;
    localparam int Y_W = ((TERM_W > SAMPLE_BITS) ? TERM_W : SAMPLE_BITS) + 1;
    localparam logic signed [Y_W-1:0] S_MAX =
        {{(Y_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [Y_W-1:0] S_MIN = ~S_MAX;
    localparam logic [Q_BITS-1:0]     CAP   = Q_BITS'(ALPHA_CAP);
    localparam logic signed [Q_BITS:0] A_ONE = (Q_BITS+1)'(ALPHA_ONE);
    localparam logic signed [Q_BITS:0] A_LIM = (Q_BITS+1)'(ALPHA_LIMIT);

    logic [STAGES-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // stage 1: round quotient, cap, apply sign
    logic [Q_BITS:0]           q_inc;
    logic [Q_BITS-1:0]         q_half;
    logic [Q_BITS-1:0]         mag;
    logic signed [Q_BITS-1:0]  alpha1;
    logic signed [Q_BITS-1:0]  alpha1_reg;
    side_t                     side1_reg;
    logic [SAMPLE_BITS-1:0]    early1_reg;

    always_comb
    begin
        q_inc  = {1'b0, quot} + (Q_BITS+1)'(1);
        q_half = q_inc[Q_BITS:1];
        if (side.num_zero)
        begin
            mag = '0;
        end
        else if (ovf || (q_half > CAP))
        begin
            mag = CAP;
        end
        else
        begin
            mag = q_half;
        end
        alpha1 = side.neg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alpha1_reg <= alpha1;
            side1_reg  <= side;
            early1_reg <= early;
        end
    end

    // stage 2: optional inversion and clip to the alpha range
    logic signed [Q_BITS:0]    a_inv;
    logic signed [ALPHA_W-1:0] alpha2;
    side_t                     side2;
    logic signed [ALPHA_W-1:0] alpha2_reg;
    side_t                     side2_reg;
    logic [SAMPLE_BITS-1:0]    early2_reg;

    always_comb
    begin
        a_inv = invert_terraces ? A_ONE - (Q_BITS+1)'(alpha1_reg)
                                : (Q_BITS+1)'(alpha1_reg);
        side2 = side1_reg;
        if (a_inv > A_LIM)
        begin
            alpha2 = ALPHA_W'(A_LIM);
            if (side1_reg.kind == KIND_SEG)
            begin
                side2.flag = 1'b1;
            end
        end
        else if (a_inv < -A_LIM)
        begin
            alpha2 = ALPHA_W'(-A_LIM);
            if (side1_reg.kind == KIND_SEG)
            begin
                side2.flag = 1'b1;
            end
        end
        else
        begin
            alpha2 = ALPHA_W'(a_inv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alpha2_reg <= alpha2;
            side2_reg  <= side2;
            early2_reg <= early1_reg;
        end
    end

    // stage 3: alpha squared
    logic signed [2*ALPHA_W-1:0] sq;
    logic [A2_W-1:0]             a2_reg;
    side_t                       side3_reg;
    logic [SAMPLE_BITS-1:0]      early3_reg;

    assign sq = alpha2_reg * alpha2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg     <= sq[A2_W-1:0];
            side3_reg  <= side2_reg;
            early3_reg <= early2_reg;
        end
    end

    // stage 4: round square to 16 fraction bits
    logic [A2_W:0]           a2_sum;
    logic [A2R_W-1:0]        a2r_reg;
    side_t                   side4_reg;
    logic [SAMPLE_BITS-1:0]  early4_reg;

    assign a2_sum = {1'b0, a2_reg} + (A2_W+1)'(ROUND_HALF);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2r_reg    <= a2_sum[ALPHA_FRAC +: A2R_W];
            side4_reg  <= side3_reg;
            early4_reg <= early3_reg;
        end
    end

    // stage 5: span times weight
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    side_t                    side5_reg;
    logic [SAMPLE_BITS-1:0]   early5_reg;

    assign prod = side4_reg.diff * $signed({1'b0, a2r_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= prod;
            side5_reg  <= side4_reg;
            early5_reg <= early4_reg;
        end
    end

    // stage 6: round half up to an integer
    logic signed [PROD_W:0]   t_sum;
    logic signed [TERM_W-1:0] term_reg;
    side_t                    side6_reg;
    logic [SAMPLE_BITS-1:0]   early6_reg;

    assign t_sum = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(ROUND_HALF);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg   <= $signed(t_sum[PROD_W:ALPHA_FRAC]);
            side6_reg  <= side5_reg;
            early6_reg <= early5_reg;
        end
    end

    // stage 7: add base, clip, select result
    logic signed [Y_W-1:0]  y_sum;
    logic [SAMPLE_BITS-1:0] out_next;
    logic                   sat_next;
    logic [SAMPLE_BITS-1:0] out_reg;
    logic                   sat_reg;

    always_comb
    begin
        y_sum = Y_W'(side6_reg.v0) + Y_W'(term_reg);
        unique case (side6_reg.kind)
            KIND_SEG:
            begin
                if (y_sum > S_MAX)
                begin
                    out_next = SAMPLE_BITS'(S_MAX);
                    sat_next = 1'b1;
                end
                else if (y_sum < S_MIN)
                begin
                    out_next = SAMPLE_BITS'(S_MIN);
                    sat_next = 1'b1;
                end
                else
                begin
                    out_next = SAMPLE_BITS'(y_sum);
                    sat_next = side6_reg.flag;
                end
            end
            KIND_PASS, KIND_END:
            begin
                out_next = early6_reg;
                sat_next = side6_reg.flag;
            end
            default:
            begin
                out_next = early6_reg;
                sat_next = side6_reg.flag;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid  = vld_reg[STAGES-1];
    assign sample_out = out_reg;
    assign saturated  = sat_reg;

endmodule

### sv/terrace_curve_mapper.sv
`timescale 1ns / 1ps
// terrace curve mapper top level: configuration registers and pipeline
//
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+---------------------------
//  sample    | sample_valid | sample_stall | sample_in
//  result    | result_valid | result_stall | sample_out, saturated
//  config    | psel/penable | pready (=1)  | pwrite, paddr, pwdata, prdata
//
//  one transaction per cycle unless the result is stalled; 3 front stages, 27 divider
//  stages (range check plus one quotient bit per stage for 26 bits), 7 back stages
//  the divider's one-bit-per-stage chain sets the depth
//  reset clears all valid bits and the configuration registers to zero
//  a stalled result freezes every stage; sample_stall rises in the same cycle
module terrace_curve_mapper #(
    parameter int MAX_POINTS  = 6,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [SAMPLE_BITS-1:0]             sample_in,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [SAMPLE_BITS-1:0]             sample_out,
    output logic                               saturated,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [tcm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import tcm_pkg::*;

    localparam int X_W        = (SAMPLE_BITS > PT_W) ? SAMPLE_BITS : PT_W;
    localparam int DIV_W      = X_W + 1 + ALPHA_FRAC + 1;
    localparam int SIDE_VEC_W = SIDE_W + SAMPLE_BITS;

    // configuration registers
    logic [CNT_W-1:0]                       count_reg;
    logic                                   invert_reg;
    logic [MAX_POINTS-1:0][2*PT_W-1:0]      point_reg;
    logic [REG_IDX_W-1:0]                   reg_idx;
    logic                                   wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            invert_reg <= 1'b0;
            point_reg  <= '0;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_COUNT)
            begin
                count_reg <= pwdata[CNT_W-1:0];
            end
            if (reg_idx == REG_INVERT)
            begin
                invert_reg <= pwdata[0];
            end
            for (int p = 0; p < MAX_POINTS; p++)
            begin
                if (reg_idx == REG_POINT_BASE + REG_IDX_W'(p))
                begin
                    point_reg[p] <= pwdata[2*PT_W-1:0];
                end
            end
        end
    end

    // register read back
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_COUNT)
        begin
            prdata = CFG_DATA_W'(count_reg);
        end
        else if (reg_idx == REG_INVERT)
        begin
            prdata = CFG_DATA_W'(invert_reg);
        end
        else
        begin
            for (int p = 0; p < MAX_POINTS; p++)
            begin
                if (reg_idx == REG_POINT_BASE + REG_IDX_W'(p))
                begin
                    prdata = CFG_DATA_W'(point_reg[p]);
                end
            end
        end
    end

    // global advance: the pipeline moves unless the result is held
    logic adv;

    assign adv          = !result_valid || !result_stall;
    assign sample_stall = !adv;

    // front stages
    logic                       front_valid;
    side_t                      front_side;
    logic [SAMPLE_BITS-1:0]     front_early;
    logic [DIV_W-1:0]           front_dividend;
    logic [DEN_W-1:0]           front_divisor;

    tcm_front #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .X_W         (X_W),
        .DIV_W       (DIV_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (sample_valid),
        .sample_in       (sample_in),
        .point_count     (count_reg),
        .invert_terraces (invert_reg),
        .points          (point_reg),
        .out_valid       (front_valid),
        .side            (front_side),
        .early           (front_early),
        .dividend        (front_dividend),
        .divisor         (front_divisor)
    );

    // divider
    logic [SIDE_VEC_W-1:0]  div_side_in;
    logic [SIDE_VEC_W-1:0]  div_side_out;
    logic                   div_valid;
    logic [Q_BITS-1:0]      div_quot;
    logic                   div_ovf;

    assign div_side_in = {front_side, front_early};

    tcm_divider #(
        .DIV_W  (DIV_W),
        .SIDE_W (SIDE_VEC_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .dividend  (front_dividend),
        .divisor   (front_divisor),
        .side_in   (div_side_in),
        .out_valid (div_valid),
        .quot      (div_quot),
        .ovf       (div_ovf),
        .side_out  (div_side_out)
    );

    // back stages
    side_t                  back_side;
    logic [SAMPLE_BITS-1:0] back_early;

    assign back_side  = side_t'(div_side_out[SIDE_VEC_W-1:SAMPLE_BITS]);
    assign back_early = div_side_out[SAMPLE_BITS-1:0];

    tcm_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (div_valid),
        .quot            (div_quot),
        .ovf             (div_ovf),
        .side            (back_side),
        .early           (back_early),
        .invert_terraces (invert_reg),
        .out_valid       (result_valid),
        .sample_out      (sample_out),
        .saturated       (saturated)
    );

endmodule

### sv/tcm_checker.sv
`timescale 1ns / 1ps
// port-level checks for the terrace curve mapper, bound to the top level
module tcm_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    input  logic                               sample_stall,
    input  logic [SAMPLE_BITS-1:0]             sample_in,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  logic [SAMPLE_BITS-1:0]             sample_out,
    input  logic                               saturated,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]     pwdata,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]     prdata,
    input  logic                               pready
);
    import tcm_pkg::*;

    // a held result transaction keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(sample_out) && $stable(saturated)))
        else $error("result payload changed while stalled");

    // input is only stalled when the output is full and held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("sample stalled without a held result");

    // point count reads back within its field
    a_count_read: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && !pwrite && (paddr[CFG_ADDR_W-1:2] == REG_COUNT)) |->
            (prdata[CFG_DATA_W-1:CNT_W] == '0))
        else $error("point count read has stray bits");

    // invert flag reads back as a single bit
    a_invert_read: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && !pwrite && (paddr[CFG_ADDR_W-1:2] == REG_INVERT)) |->
            (prdata[CFG_DATA_W-1:1] == '0))
        else $error("invert flag read has stray bits");

endmodule

bind terrace_curve_mapper tcm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tcm_checker (.*);

### verif/tb_terrace_curve_mapper.sv
`timescale 1ns / 1ps
// self-checking testbench for the terrace curve mapper
module tb_terrace_curve_mapper;
    import tcm_pkg::*;

    localparam int MAX_PTS    = 6;
    localparam int SMP_W      = 16;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int DRAIN_WAIT = 40;
    localparam int PHASES     = 10;
    localparam int PHASE_ITEMS = 100;

    // one mapped sample as the result channel carries it
    typedef struct packed {
        logic [SMP_W-1:0] value;
        logic             sat;
    } mapped_t;

    // curve setups used by the directed part
    typedef enum logic [2:0] {
        PRE_NONE,
        PRE_SINGLE,
        PRE_RAMP,
        PRE_RAMP_INV,
        PRE_FLAT,
        PRE_STEEP,
        PRE_FULL
    } preset_t;

    // one directed probe: curve setup, sample and, where obvious, the answer
    typedef struct packed {
        preset_t          preset;
        logic [SMP_W-1:0] sample;
        logic             known;
        logic [SMP_W-1:0] want;
        logic             want_sat;
    } probe_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    logic [SMP_W-1:0]      sample_in = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [SMP_W-1:0]      sample_out;
    logic                  saturated;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow copy of the curve registers
    logic [CNT_W-1:0]      cur_count = '0;
    logic                  cur_invert = 1'b0;
    logic [31:0]           cur_points [MAX_PTS];
    logic [31:0]           plan_points [MAX_PTS];

    mapped_t               expected_maps [$];
    mapped_t               expected_head;
    bit                    steady = 1'b0;
    int                    mismatches = 0;
    int                    results_seen = 0;
    int                    directed_sent = 0;
    int                    random_sent = 0;
    int                    curve_settings = 0;

    probe_t probe_table [0:24] = '{
        // reset state passes samples straight through
        '{PRE_NONE,     16'h8000, 1'b1, 16'h8000, 1'b0},
        '{PRE_NONE,     16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
        '{PRE_NONE,     16'h1234, 1'b1, 16'h1234, 1'b0},
        // a single point still passes through
        '{PRE_SINGLE,   16'h8001, 1'b1, 16'h8001, 1'b0},
        // four-point ramp: both ends, exact last input, interior
        '{PRE_RAMP,     16'h8000, 1'b1, 16'hE000, 1'b0},
        '{PRE_RAMP,     16'h7FFF, 1'b1, 16'h3000, 1'b0},
        '{PRE_RAMP,     16'h4000, 1'b1, 16'h3000, 1'b0},
        '{PRE_RAMP,     16'h0000, 1'b0, 16'h0000, 1'b0},
        '{PRE_RAMP,     16'hF000, 1'b0, 16'h0000, 1'b0},
        '{PRE_RAMP,     16'hC000, 1'b0, 16'h0000, 1'b0},
        // same ramp, inverted terraces
        '{PRE_RAMP_INV, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{PRE_RAMP_INV, 16'h2000, 1'b0, 16'h0000, 1'b0},
        '{PRE_RAMP_INV, 16'h8000, 1'b1, 16'hE000, 1'b0},
        // flat segment: zero divisor with zero, negative, positive numerator
        '{PRE_FLAT,     16'h0800, 1'b1, 16'h0800, 1'b1},
        '{PRE_FLAT,     16'h0000, 1'b1, 16'h0800, 1'b1},
        '{PRE_FLAT,     16'h1000, 1'b1, 16'h0800, 1'b1},
        '{PRE_FLAT,     16'h2000, 1'b1, 16'h0800, 1'b0},
        '{PRE_FLAT,     16'hDFFF, 1'b1, 16'h0800, 1'b0},
        // steep inverted segment drives alpha and result into clipping
        '{PRE_STEEP,    16'h7000, 1'b0, 16'h0000, 1'b0},
        '{PRE_STEEP,    16'h9000, 1'b0, 16'h0000, 1'b0},
        '{PRE_STEEP,    16'h8800, 1'b0, 16'h0000, 1'b0},
        // count above the maximum acts as six points
        '{PRE_FULL,     16'h8000, 1'b1, 16'h8000, 1'b0},
        '{PRE_FULL,     16'h7FFF, 1'b1, 16'h2000, 1'b0},
        '{PRE_FULL,     16'h0000, 1'b0, 16'h0000, 1'b0},
        '{PRE_FULL,     16'hA000, 1'b0, 16'h0000, 1'b0}
    };

    terrace_curve_mapper #(
        .MAX_POINTS  (MAX_PTS),
        .SAMPLE_BITS (SMP_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .saturated    (saturated),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < 8);
    endfunction

    function automatic longint point_in(int i);
        return longint'($signed(cur_points[i][31:16]));
    endfunction

    function automatic longint point_out(int i);
        return longint'($signed(cur_points[i][15:0]));
    endfunction

    // expected terrace mapping of one sample under the current curve
    function automatic mapped_t curve_map(logic [SMP_W-1:0] raw);
        longint x, v0, v1, num, den, alpha, a2, prod, y, swap;
        longint unsigned un, ud, q;
        int n, pos, i0, i1, i;
        bit hit, sat;
        mapped_t r;
        x = longint'($signed(raw));
        sat = 1'b0;
        n = (cur_count > MAX_PTS) ? MAX_PTS : int'(cur_count);
        if (n < 2)
            y = x;
        else
        begin
            // first point whose input lies above the sample
            pos = n;
            hit = 1'b0;
            for (i = 0; i < n; i++)
                if (!hit && x < point_in(i))
                begin
                    pos = i;
                    hit = 1'b1;
                end
            i0 = (pos == 0) ? 0 : pos - 1;
            i1 = (pos > n - 1) ? n - 1 : pos;
            if (i0 == i1)
                y = point_out(i1);
            else
            begin
                v0 = point_out(i0);
                v1 = point_out(i1);
                num = x - v0;
                den = v1 - v0;
                // alpha with rounding to nearest, ties away from zero
                if (den == 0)
                begin
                    sat = 1'b1;
                    if (num > 0)
                        alpha = ALPHA_CAP;
                    else if (num < 0)
                        alpha = -ALPHA_CAP;
                    else
                        alpha = 0;
                end
                else
                begin
                    un = (num < 0 ? -num : num) << ALPHA_FRAC;
                    ud = den < 0 ? -den : den;
                    q = (2 * un + ud) / (2 * ud);
                    if (q > ALPHA_CAP)
                        q = ALPHA_CAP;
                    alpha = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
                end
                if (cur_invert)
                begin
                    alpha = ALPHA_ONE - alpha;
                    swap = v0;
                    v0 = v1;
                    v1 = swap;
                end
                if (alpha > ALPHA_LIMIT)
                begin
                    alpha = ALPHA_LIMIT;
                    sat = 1'b1;
                end
                if (alpha < -ALPHA_LIMIT)
                begin
                    alpha = -ALPHA_LIMIT;
                    sat = 1'b1;
                end
                // square, then interpolate with round half up
                a2 = (alpha * alpha + ROUND_HALF) >>> ALPHA_FRAC;
                prod = (v1 - v0) * a2;
                y = v0 + ((prod + ROUND_HALF) >>> ALPHA_FRAC);
            end
        end
        if (y > SAMPLE_MAX)
        begin
            y = SAMPLE_MAX;
            sat = 1'b1;
        end
        if (y < SAMPLE_MIN)
        begin
            y = SAMPLE_MIN;
            sat = 1'b1;
        end
        r.value = y[SMP_W-1:0];
        r.sat = sat;
        return r;
    endfunction

    // register write: setup cycle then access cycle
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COUNT:  cur_count = val[CNT_W-1:0];
            REG_INVERT: cur_invert = val[0];
            default:    cur_points[idx - REG_POINT_BASE] = val;
        endcase
    endtask

    // load count, invert flag and all six planned points
    task automatic write_curve(logic [31:0] count, logic [31:0] inv);
        int i;
        reg_write(REG_COUNT, count);
        reg_write(REG_INVERT, inv);
        for (i = 0; i < MAX_PTS; i++)
            reg_write(REG_IDX_W'(REG_POINT_BASE + i), plan_points[i]);
        curve_settings++;
    endtask

    // hold off the sender until every pending result is back
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (expected_maps.size() != 0)
            @(posedge clk);
    endtask

    // drive one sample transaction and queue its expected result
    task automatic send_sample(logic [SMP_W-1:0] s, bit known, mapped_t want);
        if (idle_now())
        begin
            sample_valid <= 1'b0;
            do @(posedge clk); while (idle_now());
        end
        sample_valid <= 1'b1;
        sample_in <= s;
        do @(posedge clk); while (sample_stall);
        expected_maps.push_back(known ? want : curve_map(s));
    endtask

    task automatic apply_preset(preset_t p);
        logic [31:0] count, inv;
        int i;
        for (i = 0; i < MAX_PTS; i++)
            plan_points[i] = (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
        inv = 32'd0;
        count = 32'd2;
        case (p)
            PRE_SINGLE:
            begin
                count = 32'd1;
                plan_points[0] = 32'h4000_1000;
            end
            PRE_RAMP, PRE_RAMP_INV:
            begin
                count = 32'd4;
                inv = (p == PRE_RAMP_INV) ? 32'd1 : 32'd0;
                plan_points[0] = 32'hC000_E000;
                plan_points[1] = 32'hF000_F000;
                plan_points[2] = 32'h1000_0800;
                plan_points[3] = 32'h4000_3000;
            end
            PRE_FLAT:
            begin
                plan_points[0] = 32'hE000_0800;
                plan_points[1] = 32'h2000_0800;
            end
            PRE_STEEP:
            begin
                inv = 32'hFFFF_FFFF;
                plan_points[0] = 32'h8000_0000;
                plan_points[1] = 32'h7FFF_1000;
            end
            PRE_FULL:
            begin
                count = 32'hFFFF_FFFF;
                plan_points[0] = 32'h9000_8000;
                plan_points[1] = 32'hC000_C000;
                plan_points[2] = 32'hF800_0400;
                plan_points[3] = 32'h0800_F000;
                plan_points[4] = 32'h3000_7FFF;
                plan_points[5] = 32'h6000_2000;
            end
            default: ;
        endcase
        write_curve(count, inv);
    endtask

    // random curve: mostly sorted inputs, sometimes raw register words
    task automatic plan_random_curve(output logic [31:0] count, output logic [31:0] inv);
        int i, pin, pout;
        bit raw;
        raw = ($urandom_range(0, 3) == 0);
        pin = $urandom_range(0, 24000) - 32768;
        for (i = 0; i < MAX_PTS; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                pout = $urandom_range(0, 65535) - 32768;
            else
                pout = pin + $urandom_range(0, 8192) - 4096;
            plan_points[i] = raw ? $urandom() : {pin[15:0], pout[15:0]};
            pin = pin + $urandom_range(1, 12000);
            if (pin > SAMPLE_MAX)
                pin = SAMPLE_MAX;
        end
        count = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(2, 7);
        inv = $urandom();
    endtask

    function automatic logic [SMP_W-1:0] pick_sample();
        int k, j;
        k = $urandom_range(0, 9);
        j = $urandom_range(0, MAX_PTS - 1);
        if (k < 5)
            return cur_points[j][31:16] + SMP_W'($urandom_range(0, 2048) - 1024);
        else if (k < 8)
            return SMP_W'($urandom());
        else if (k == 8)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return cur_points[j][15:0] + SMP_W'($urandom_range(0, 512) - 256);
    endfunction

    // result checker and random result stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_maps.size() == 0)
            begin
                $error("result transaction with nothing expected: sample_out %h saturated %b",
                       sample_out, saturated);
                mismatches++;
            end
            else
            begin
                expected_head = expected_maps.pop_front();
                if (sample_out !== expected_head.value)
                begin
                    $error("sample_out: expected %h, got %h", expected_head.value, sample_out);
                    mismatches++;
                end
                if (saturated !== expected_head.sat)
                begin
                    $error("saturated: expected %b, got %b", expected_head.sat, saturated);
                    mismatches++;
                end
            end
        end
        result_stall <= idle_now();
    end

    // stimulus
    initial
    begin
        int r, p, k;
        preset_t active;
        logic [31:0] count, inv;
        mapped_t want;

        for (k = 0; k < MAX_PTS; k++)
            cur_points[k] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed probes
        active = PRE_NONE;
        for (r = 0; r < $size(probe_table); r++)
        begin
            if (probe_table[r].preset != PRE_NONE && probe_table[r].preset != active)
            begin
                drain_results();
                apply_preset(probe_table[r].preset);
                active = probe_table[r].preset;
            end
            want = {probe_table[r].want, probe_table[r].want_sat};
            send_sample(probe_table[r].sample, probe_table[r].known, want);
            directed_sent++;
        end

        // random curves, one quiet phase with no idling on either side
        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            steady = (p == 4);
            plan_random_curve(count, inv);
            write_curve(count, inv);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                send_sample(pick_sample(), 1'b0, '0);
                random_sent++;
            end
        end
        steady = 1'b0;
        sample_valid <= 1'b0;

        while (expected_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d directed and %0d random samples over %0d curve settings",
                 directed_sent, random_sent, curve_settings);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_maps.size() == 0)
            $display("terrace_curve_mapper verification clean");
        else
            $display("terrace_curve_mapper verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("timeout with %0d results outstanding", expected_maps.size());
        $display("terrace_curve_mapper verification failed");
        $finish;
    end

endmodule

### sim.f
sv/tcm_pkg.sv
sv/tcm_front.sv
sv/tcm_divider.sv
sv/tcm_back.sv
sv/terrace_curve_mapper.sv
sv/tcm_checker.sv
verif/tb_terrace_curve_mapper.sv
